// File: rtl/retro_video_byte_pixel_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte pixel decoder
// Implication checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RETRO_VIDEO_BYTE_PIXEL_DECODER_ASSERT_SVH
`define RETRO_VIDEO_BYTE_PIXEL_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RVBPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RVBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RVBPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RVBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/rvbpd_pkg.sv
// ----------------------------------------------------------------------------
// Byte pixel decoder package
// Mode and kind codes, the decoded word type and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rvbpd_pkg;

	localparam logic [2:0] MODE_HIRES_COLOR  = 3'd0;
	localparam logic [2:0] MODE_HIRES_MONO   = 3'd1;
	localparam logic [2:0] MODE_LORES        = 3'd2;
	localparam logic [2:0] MODE_DHIRES_COLOR = 3'd3;
	localparam logic [2:0] MODE_DHIRES_MONO  = 3'd4;

	localparam logic [1:0] KIND_COLOR8  = 2'd0;
	localparam logic [1:0] KIND_COLOR16 = 2'd1;
	localparam logic [1:0] KIND_MONO    = 2'd2;

	localparam int MAX_PIX = 7;

	typedef logic [MAX_PIX-1:0][3:0] code_list_t;

	typedef struct packed {
		code_list_t codes;
		logic [1:0] kind;
		logic [1:0] rep;
		logic [2:0] count;
	} dec_t;

	// Number of double hi-res bits carried in from earlier bytes: (7 * column) mod 4.
	function automatic logic [1:0] grp_phase(input logic [6:0] col);
		grp_phase = 2'(~col[1:0] + 2'd1);
	endfunction

	// Keeps the low n bits of a three-bit value.
	function automatic logic [2:0] low_bits(input logic [2:0] v, input logic [1:0] n);
		logic [2:0] m;
		case (n)
			2'd0: m = 3'b000;
			2'd1: m = 3'b001;
			2'd2: m = 3'b011;
			default: m = 3'b111;
		endcase
		low_bits = v & m;
	endfunction

endpackage

// File: rtl/rvbpd_in_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one video memory byte with its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rvbpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [6:0] column;
	logic [2:0] cell_row;

	modport source (output valid, output data_byte, output column, output cell_row,
		input ready);
	modport sink (input valid, input data_byte, input column, input cell_row,
		output ready);
endinterface

// File: rtl/rvbpd_out_if.sv
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying one pixel code per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rvbpd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_code;
	logic [1:0] code_kind;
	logic [1:0] pixel_repeat;
	logic       last_of_item;

	modport source (output valid, output pixel_code, output code_kind,
		output pixel_repeat, output last_of_item, input ready);
	modport sink (input valid, input pixel_code, input code_kind,
		input pixel_repeat, input last_of_item, output ready);
endinterface

// File: rtl/rvbpd_decode.sv
// ----------------------------------------------------------------------------
// Byte decode
// Turns one registered byte and its line context into a list of pixel codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rvbpd_decode (
	input  logic [7:0]          data_byte,
	input  logic [6:0]          column,
	input  logic [2:0]          cell_row,
	input  logic [2:0]          mode,
	input  logic                prev6,
	input  logic [2:0]          pend,
	output rvbpd_pkg::dec_t     dec
);

	logic [1:0] phase;
	logic [2:0] pend_m;
	logic [9:0] stream;
	logic [3:0] nib;
	logic [3:0] sh0;
	logic [3:0] sh1;
	logic       lo;
	logic       cur;
	logic       evenb;
	logic       oddb;

	assign phase  = rvbpd_pkg::grp_phase(column);
	assign pend_m = rvbpd_pkg::low_bits(pend, phase);
	assign nib    = (cell_row < 3'd4) ? data_byte[3:0] : data_byte[7:4];
	assign sh0    = 4'({2'b00, phase} + 4'd3);
	assign sh1    = 4'({2'b00, phase} - 4'd1);

	always_comb begin
		stream[9:7] = pend_m;
		for (int k = 0; k < 7; k++) begin
			stream[6-k] = data_byte[k];
		end
	end

	always_comb begin
		dec       = '0;
		lo        = 1'b0;
		cur       = 1'b0;
		evenb     = 1'b0;
		oddb      = 1'b0;
		case (mode)
			rvbpd_pkg::MODE_HIRES_COLOR: begin
				dec.kind  = rvbpd_pkg::KIND_COLOR8;
				dec.rep   = 2'd1;
				dec.count = 3'd7;
				for (int k = 0; k < 7; k++) begin
					lo  = (k == 0) ? prev6 : data_byte[(k+6)%7];
					cur = data_byte[k];
					if ((k % 2) == 0) begin
						evenb = cur;
						oddb  = lo;
					end else begin
						evenb = lo;
						oddb  = cur;
					end
					if (!column[0]) begin
						dec.codes[k] = {1'b0, data_byte[7], evenb, oddb};
					end else begin
						dec.codes[k] = {1'b0, data_byte[7], oddb, evenb};
					end
				end
			end
			rvbpd_pkg::MODE_HIRES_MONO: begin
				dec.kind  = rvbpd_pkg::KIND_MONO;
				dec.rep   = 2'd1;
				dec.count = 3'd7;
				for (int k = 0; k < 7; k++) begin
					dec.codes[k] = {3'b000, data_byte[k]};
				end
			end
			rvbpd_pkg::MODE_LORES: begin
				dec.kind  = rvbpd_pkg::KIND_COLOR16;
				dec.rep   = 2'd1;
				dec.count = 3'd7;
				for (int k = 0; k < 7; k++) begin
					dec.codes[k] = nib;
				end
			end
			rvbpd_pkg::MODE_DHIRES_COLOR: begin
				dec.kind     = rvbpd_pkg::KIND_COLOR16;
				dec.rep      = 2'd2;
				dec.codes[0] = stream[sh0 +: 4];
				if (phase == 2'd0) begin
					dec.count = 3'd1;
				end else begin
					dec.count    = 3'd2;
					dec.codes[1] = stream[sh1 +: 4];
				end
			end
			rvbpd_pkg::MODE_DHIRES_MONO: begin
				dec.kind = rvbpd_pkg::KIND_MONO;
				dec.rep  = 2'd1;
				if (!column[0]) begin
					dec.count = 3'd4;
					for (int k = 0; k < 4; k++) begin
						dec.codes[k] = {3'b000, data_byte[2*k]};
					end
				end else begin
					dec.count = 3'd3;
					for (int k = 0; k < 3; k++) begin
						dec.codes[k] = {3'b000, data_byte[2*k+1]};
					end
				end
			end
			default: begin
				dec.count = 3'd0;
			end
		endcase
	end

endmodule

// File: rtl/rvbpd_serializer.sv
// ----------------------------------------------------------------------------
// Pixel serializer
// Holds one decoded code list and sends it out one word per cycle while the output is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rvbpd_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	output logic                 load_ready,
	input  rvbpd_pkg::dec_t      dec,
	rvbpd_out_if.source          pix_out
);

	rvbpd_pkg::code_list_t codes_q;
	logic [1:0]            kind_q;
	logic [1:0]            rep_q;
	logic [2:0]            rem_q;
	logic                  send;

	assign send       = pix_out.valid && pix_out.ready;
	assign load_ready = (rem_q == 3'd0) || ((rem_q == 3'd1) && pix_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load_valid && load_ready) begin
			rem_q <= dec.count;
		end else if (send) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			codes_q <= dec.codes;
			kind_q  <= dec.kind;
			rep_q   <= dec.rep;
		end else if (send) begin
			codes_q <= {4'd0, codes_q[rvbpd_pkg::MAX_PIX-1:1]};
		end
	end

	assign pix_out.valid        = (rem_q != 3'd0);
	assign pix_out.pixel_code   = codes_q[0];
	assign pix_out.code_kind    = kind_q;
	assign pix_out.pixel_repeat = rep_q;
	assign pix_out.last_of_item = (rem_q == 3'd1);

endmodule

// File: rtl/retro_video_byte_pixel_decoder.sv
// ----------------------------------------------------------------------------
// Retro video byte pixel decoder
// Decodes video memory bytes into pixel codes for five bitmap modes.
// ----------------------------------------------------------------------------
//  channel     direction  contents
//  pix_in      sink       data_byte, column, cell_row
//  pix_out     source     pixel_code, code_kind, pixel_repeat, last_of_item
//  cfg         write      video_mode
//
// A byte is registered, decoded from the register and loaded into the serializer,
// which sends one word per cycle while the output is ready: seven words per byte
// in most modes, one to four in double hi-res modes, none for unused mode codes.
// The serializer output sets the rate; a new byte loads as its last word leaves.
// Reset clears the mode, the line state and all valid flags.
// A stalled output holds its word and backs up into the input register.
`timescale 1ns / 1ps
`include "retro_video_byte_pixel_decoder_assert.svh"
module retro_video_byte_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	rvbpd_in_if.sink    pix_in,
	rvbpd_out_if.source pix_out
);

	logic [2:0]      video_mode_q;
	logic            prev6_q;
	logic [2:0]      pend_q;
	logic            valid_s1;
	logic [7:0]      data_s1;
	logic [6:0]      col_s1;
	logic [2:0]      row_s1;
	logic [2:0]      mode_s1;
	logic            prev6_s1;
	logic [2:0]      pend_s1;
	logic            accept;
	logic            ser_ready;
	logic            line_start;
	logic [1:0]      keep_n;
	rvbpd_pkg::dec_t dec;

	assign pix_in.ready = !valid_s1 || ser_ready;
	assign accept       = pix_in.valid && pix_in.ready;
	assign line_start   = (pix_in.column == 7'd0);
	assign keep_n       = 2'(rvbpd_pkg::grp_phase(pix_in.column) + 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_mode_q <= rvbpd_pkg::MODE_HIRES_COLOR;
		end else if (cfg_we) begin
			video_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev6_q  <= 1'b0;
			pend_q   <= 3'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				prev6_q  <= pix_in.data_byte[6];
				pend_q   <= rvbpd_pkg::low_bits({pix_in.data_byte[4], pix_in.data_byte[5],
					pix_in.data_byte[6]}, keep_n);
				valid_s1 <= 1'b1;
			end else if (ser_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= pix_in.data_byte;
			col_s1   <= pix_in.column;
			row_s1   <= pix_in.cell_row;
			mode_s1  <= video_mode_q;
			prev6_s1 <= line_start ? 1'b0 : prev6_q;
			pend_s1  <= line_start ? 3'd0 : pend_q;
		end
	end

	rvbpd_decode u_decode (
		.data_byte (data_s1),
		.column    (col_s1),
		.cell_row  (row_s1),
		.mode      (mode_s1),
		.prev6     (prev6_s1),
		.pend      (pend_s1),
		.dec       (dec)
	);

	rvbpd_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (ser_ready),
		.dec        (dec),
		.pix_out    (pix_out)
	);

	`RVBPD_ASSERT_NEXT(a_line_start_clears, clk, arst_n, accept && line_start, valid_s1 && !prev6_s1 && (pend_s1 == 3'd0), "line start did not clear the line state")
	`RVBPD_ASSERT_SAME(a_last_blocks_load, clk, arst_n, pix_out.valid && pix_out.last_of_item && !pix_out.ready, !ser_ready, "serializer loaded over an unsent last word")
	`RVBPD_ASSERT_SAME(a_double_is_color16, clk, arst_n, pix_out.valid && (pix_out.pixel_repeat == 2'd2), pix_out.code_kind == rvbpd_pkg::KIND_COLOR16, "double width word without a sixteen color code")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pixel decoder regression
// Drives video memory bytes through the valid/ready input channel in every
// mode, predicts the pixel words of each accepted byte and checks every word
// that leaves the output channel against the oldest prediction, under random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
	localparam int DRAIN_SLACK   = 20;
	localparam int HOLD_CYCLES   = 200;
	localparam int WATCHDOG_IDLE = 3000;

	typedef struct packed {
		logic [3:0] code;
		logic [1:0] kind;
		logic [1:0] rep;
		logic       last;
	} pix_word_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	rvbpd_in_if  in_if ();
	rvbpd_out_if out_if ();

	retro_video_byte_pixel_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix_in    (in_if.sink),
		.pix_out   (out_if.source)
	);

	pix_word_t  expected_pixels[$];
	int         errors;
	logic [2:0] mode_model;
	logic       prev_bit6_model;
	logic [2:0] carry_bits_model;
	bit         src_bursts;
	bit         sink_bursts;
	int         hold_asks;
	int         idle_cycles;
	logic [6:0] next_column;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Expected pixel words of one accepted byte, with the line state update.
	task automatic predict_pixels(input logic [7:0] d, input logic [6:0] col,
			input logic [2:0] row);
		int         carry_n;
		int         nbits;
		logic [9:0] stream;
		logic       lo;
		logic       evenb;
		logic       oddb;
		logic [3:0] nib;
		pix_word_t  w;
		pix_word_t  words[$];
		if (col == 7'd0) begin
			prev_bit6_model  = 1'b0;
			carry_bits_model = 3'b000;
		end
		carry_n = (7 * int'(col)) % 4;
		stream  = 10'(carry_bits_model & 3'((1 << carry_n) - 1));
		for (int k = 0; k < 7; k++) stream = {stream[8:0], d[k]};
		nbits = carry_n + 7;
		case (mode_model)
			rvbpd_pkg::MODE_HIRES_COLOR: begin
				for (int k = 0; k < 7; k++) begin
					lo = (k == 0) ? prev_bit6_model : d[k-1];
					if ((k % 2) == 0) begin
						evenb = d[k];
						oddb  = lo;
					end else begin
						evenb = lo;
						oddb  = d[k];
					end
					w.code = col[0] ? {1'b0, d[7], oddb, evenb} : {1'b0, d[7], evenb, oddb};
					w.kind = rvbpd_pkg::KIND_COLOR8;
					w.rep  = 2'd1;
					w.last = 1'b0;
					words.push_back(w);
				end
			end
			rvbpd_pkg::MODE_HIRES_MONO: begin
				for (int k = 0; k < 7; k++) begin
					w = '{code: {3'b000, d[k]}, kind: rvbpd_pkg::KIND_MONO,
						rep: 2'd1, last: 1'b0};
					words.push_back(w);
				end
			end
			rvbpd_pkg::MODE_LORES: begin
				nib = (row < 3'd4) ? d[3:0] : d[7:4];
				for (int k = 0; k < 7; k++) begin
					w = '{code: nib, kind: rvbpd_pkg::KIND_COLOR16, rep: 2'd1, last: 1'b0};
					words.push_back(w);
				end
			end
			rvbpd_pkg::MODE_DHIRES_COLOR: begin
				for (int g = 0; g < nbits / 4; g++) begin
					w.code = 4'(stream >> (nbits - 4 - 4 * g));
					w.kind = rvbpd_pkg::KIND_COLOR16;
					w.rep  = 2'd2;
					w.last = 1'b0;
					words.push_back(w);
				end
			end
			rvbpd_pkg::MODE_DHIRES_MONO: begin
				for (int k = 0; k < 7; k++) begin
					if (((int'(col) + k) % 2) == 0) begin
						w = '{code: {3'b000, d[k]}, kind: rvbpd_pkg::KIND_MONO,
							rep: 2'd1, last: 1'b0};
						words.push_back(w);
					end
				end
			end
			default: begin
			end
		endcase
		carry_bits_model = 3'(stream & 10'((1 << (nbits % 4)) - 1));
		prev_bit6_model  = d[6];
		if (words.size() > 0) words[words.size()-1].last = 1'b1;
		foreach (words[i]) expected_pixels.push_back(words[i]);
	endtask

	task automatic send_byte(input logic [7:0] d, input logic [6:0] col,
			input logic [2:0] row);
		int gap;
		if (src_bursts && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid     <= 1'b1;
		in_if.data_byte <= d;
		in_if.column    <= col;
		in_if.cell_row  <= row;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		predict_pixels(d, col, row);
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic set_mode(input logic [2:0] m);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we     <= 1'b0;
		mode_model  = m;
	endtask

	// Mostly running scanlines from column 0, with some jumps to any column.
	task automatic send_random_line_bytes(input int count);
		logic [6:0] col;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) col = 7'($urandom_range(0, 127));
			else if (next_column > 7'd79 || $urandom_range(0, 39) == 0) col = 7'd0;
			else col = next_column;
			next_column = col + 7'd1;
			send_byte(8'($urandom_range(0, 255)), col, 3'($urandom_range(0, 7)));
		end
	endtask

	task automatic test_reset_mode();
		send_byte(8'h00, 7'd0, 3'd0);
		send_byte(8'hFF, 7'd1, 3'd7);
	endtask

	task automatic test_directed_modes();
		set_mode(rvbpd_pkg::MODE_HIRES_COLOR);
		send_byte(8'hC0, 7'd0, 3'd0);
		send_byte(8'h01, 7'd1, 3'd7);
		send_byte(8'h55, 7'd127, 3'd3);
		set_mode(rvbpd_pkg::MODE_HIRES_MONO);
		send_byte(8'hFF, 7'd0, 3'd0);
		send_byte(8'h2A, 7'd79, 3'd4);
		set_mode(rvbpd_pkg::MODE_LORES);
		send_byte(8'hA5, 7'd0, 3'd3);
		send_byte(8'hA5, 7'd1, 3'd4);
		send_byte(8'h0F, 7'd2, 3'd7);
		set_mode(rvbpd_pkg::MODE_DHIRES_COLOR);
		send_byte(8'hFF, 7'd0, 3'd0);
		send_byte(8'h2A, 7'd1, 3'd0);
		send_byte(8'h55, 7'd3, 3'd0);
		send_byte(8'h7F, 7'd2, 3'd0);
		send_byte(8'h80, 7'd127, 3'd0);
		set_mode(rvbpd_pkg::MODE_DHIRES_MONO);
		send_byte(8'h55, 7'd0, 3'd0);
		send_byte(8'hAA, 7'd1, 3'd0);
		send_byte(8'h7F, 7'd126, 3'd0);
		for (logic [3:0] m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
			set_mode(m[2:0]);
			send_byte(8'hFF, 7'd0, 3'd7);
		end
		set_mode(rvbpd_pkg::MODE_DHIRES_COLOR);
		send_byte(8'hC3, 7'd1, 3'd0);
	endtask

	task automatic test_random_modes();
		logic [2:0] m;
		for (int seg = 0; seg < 7; seg++) begin
			m = (seg < 5) ? 3'(seg) : 3'($urandom_range(0, 7));
			set_mode(m);
			src_bursts  = (seg % 3) != 2;
			sink_bursts = (seg % 3) != 1;
			next_column = 7'd0;
			send_random_line_bytes(26);
		end
	endtask

	task automatic test_output_stall();
		set_mode(rvbpd_pkg::MODE_HIRES_COLOR);
		src_bursts  = 1'b0;
		sink_bursts = 1'b0;
		hold_asks++;
		next_column = 7'd0;
		send_random_line_bytes(20);
	endtask

	task automatic test_quiet_finish();
		set_mode(rvbpd_pkg::MODE_DHIRES_COLOR);
		src_bursts  = 1'b0;
		sink_bursts = 1'b0;
		next_column = 7'd0;
		send_random_line_bytes(25);
		set_mode(MODE_SPARE_LAST);
		send_random_line_bytes(4);
		set_mode(rvbpd_pkg::MODE_LORES);
		send_random_line_bytes(12);
	endtask

	task automatic compare_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, expv, actv);
			errors++;
		end
	endtask

	initial begin
		int hold_seen;
		int hold_left;
		int idle_left;
		hold_seen = 0;
		hold_left = 0;
		idle_left = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_if.ready <= 1'b0;
				hold_left--;
			end else if (idle_left > 0) begin
				out_if.ready <= 1'b0;
				idle_left--;
			end else if (sink_bursts && $urandom_range(0, 5) == 0) begin
				out_if.ready <= 1'b0;
				idle_left = $urandom_range(1, 11) - 1;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pix_word_t w;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected word expected none actual code %0d kind %0d rep %0d last %0d",
					$time, out_if.pixel_code, out_if.code_kind, out_if.pixel_repeat,
					out_if.last_of_item);
				errors++;
			end else begin
				w = expected_pixels.pop_front();
				compare_field("pixel_code", w.code, out_if.pixel_code);
				compare_field("code_kind", w.kind, out_if.code_kind);
				compare_field("pixel_repeat", w.rep, out_if.pixel_repeat);
				compare_field("last_of_item", w.last, out_if.last_of_item);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_IDLE) begin
				$display("retro_video_byte_pixel_decoder regression: fail");
				$finish;
			end
		end
	end

	initial begin
		errors           = 0;
		idle_cycles      = 0;
		hold_asks        = 0;
		mode_model       = rvbpd_pkg::MODE_HIRES_COLOR;
		prev_bit6_model  = 1'b0;
		carry_bits_model = 3'b000;
		src_bursts       = 1'b1;
		sink_bursts      = 1'b1;
		next_column      = 7'd0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= 3'd0;
		in_if.valid     <= 1'b0;
		in_if.data_byte <= 8'h00;
		in_if.column    <= 7'd0;
		in_if.cell_row  <= 3'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_mode();
		test_directed_modes();
		test_random_modes();
		test_output_stall();
		test_quiet_finish();
		wait_drained();
		if (errors == 0) begin
			$display("retro_video_byte_pixel_decoder regression: pass");
		end else begin
			$display("retro_video_byte_pixel_decoder regression: fail");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/rvbpd_pkg.sv
rtl/rvbpd_in_if.sv
rtl/rvbpd_out_if.sv
rtl/rvbpd_decode.sv
rtl/rvbpd_serializer.sv
rtl/retro_video_byte_pixel_decoder.sv
test/tb_top.sv
